/* design/ggbb_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package ggbb_pkg;

  localparam int CORDIC_STEPS = 16;
  localparam int ATAN_LEN     = 24;
  localparam int CORDIC_ITERS = (CORDIC_STEPS > ATAN_LEN) ? ATAN_LEN : CORDIC_STEPS;
  localparam int CNT_W        = $clog2(ATAN_LEN);

  localparam int POS_W   = 16;
  localparam int HEAD_W  = 14;
  localparam int DW      = POS_W + 1;
  localparam int XW      = DW + 24 + 4;
  localparam int ZW      = 20;
  localparam int ERR_W   = 16;
  localparam int SPD_W   = 10;
  localparam int ANG_W   = 11;
  localparam int HTOL_W  = 13;
  localparam int PTOL_W  = 15;
  localparam int CIDX_W  = 3;
  localparam int CDATA_W = 16;

  localparam logic signed [ZW-1:0]     PI_Q15    = ZW'(102944);
  localparam logic signed [15:0]       PI_A      = 16'sd6434;
  localparam logic signed [HEAD_W-1:0] HALF_PI_A = HEAD_W'(3217);
  localparam logic signed [DW-1:0]     TWO_PI_A  = DW'(12868);
  localparam logic signed [HEAD_W-1:0] GAP_LOW   = -HEAD_W'(410);

  typedef enum logic [CIDX_W-1:0] {
    REG_GOAL_X    = 3'd0,
    REG_GOAL_Y    = 3'd1,
    REG_TURN_RATE = 3'd2,
    REG_FWD_SPEED = 3'd3,
    REG_HEAD_TOL  = 3'd4,
    REG_POS_TOL   = 3'd5
  } cfg_reg_e;

  typedef struct packed {
    logic signed [POS_W-1:0] goal_x;
    logic signed [POS_W-1:0] goal_y;
    logic [SPD_W-1:0]        turn_rate;
    logic [SPD_W-1:0]        forward_speed;
    logic [HTOL_W-1:0]       heading_tol;
    logic [PTOL_W-1:0]       position_tol;
  } cfg_t;

  function automatic logic signed [ZW-1:0] atan_q15(input logic [CNT_W-1:0] i);
    logic signed [ZW-1:0] v;
    case (i)
      5'd0:    v = ZW'(25736);
      5'd1:    v = ZW'(15193);
      5'd2:    v = ZW'(8027);
      5'd3:    v = ZW'(4075);
      5'd4:    v = ZW'(2045);
      5'd5:    v = ZW'(1024);
      5'd6:    v = ZW'(512);
      5'd7:    v = ZW'(256);
      5'd8:    v = ZW'(128);
      5'd9:    v = ZW'(64);
      5'd10:   v = ZW'(32);
      5'd11:   v = ZW'(16);
      5'd12:   v = ZW'(8);
      5'd13:   v = ZW'(4);
      5'd14:   v = ZW'(2);
      5'd15:   v = ZW'(1);
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

/* design/go_to_goal_bang_bang_steering.sv */
// channel  | handshake              | payload
// ---------+------------------------+----------------------------------------------
// pose in  | in_valid_i/in_ready_o  | pose_x_i, pose_y_i, pose_heading_i
// result   | out_valid_o/out_ready_i| angular_cmd_o, linear_cmd_o, heading_error_o
// config   | cfg_valid_i/cfg_ready_o| cfg_index_i, cfg_data_i (always ready)
//
// Each item goes through the iterative CORDIC vectoring unit, one rotation
// per cycle; axis-aligned goals skip the rotations. Reset clears config to
// defaults and the held error and forward command to zero. The result sits
// in an output register; a new item is taken while it waits, and finishes
// once it is taken.
`timescale 1ns / 1ps
`default_nettype none

module go_to_goal_bang_bang_steering (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  logic [ggbb_pkg::CIDX_W-1:0]           cfg_index_i,
  input  logic [ggbb_pkg::CDATA_W-1:0]          cfg_data_i,
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  logic signed [ggbb_pkg::POS_W-1:0]     pose_x_i,
  input  logic signed [ggbb_pkg::POS_W-1:0]     pose_y_i,
  input  logic signed [ggbb_pkg::HEAD_W-1:0]    pose_heading_i,
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output logic signed [ggbb_pkg::ANG_W-1:0]     angular_cmd_o,
  output logic [ggbb_pkg::SPD_W-1:0]            linear_cmd_o,
  output logic signed [ggbb_pkg::ERR_W-1:0]     heading_error_o
);
  import ggbb_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_START = 4'b0010,
    S_WAIT  = 4'b0100,
    S_PUSH  = 4'b1000
  } seq_state_e;

  cfg_t cfg;
  seq_state_e state_q, state_d;

  logic signed [DW-1:0]     dx_q, dy_q;
  logic signed [HEAD_W-1:0] hd_q;
  logic signed [ERR_W-1:0]  err_q, err_d;
  logic [SPD_W-1:0]         lin_q, lin_d;
  logic signed [ANG_W-1:0]  ang_q, ang_d;
  logic                     out_valid_q, out_valid_d;
  logic signed [ANG_W-1:0]  out_ang_q;
  logic [SPD_W-1:0]         out_lin_q;
  logic signed [ERR_W-1:0]  out_err_q;

  logic                     cordic_done;
  logic signed [HEAD_W-1:0] bearing;
  logic signed [DW-1:0]     err_raw, err_ext, tol_ext;
  logic [DW-1:0]            adx, ady, ptol_ext;
  logic                     in_acc, out_free;

  ggbb_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  ggbb_cordic u_cordic (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (state_q == S_START),
    .dx_i      (dx_q),
    .dy_i      (dy_q),
    .done_o    (cordic_done),
    .bearing_o (bearing)
  );

  assign in_ready_o      = (state_q == S_IDLE);
  assign in_acc          = in_valid_i && in_ready_o;
  assign out_free        = !out_valid_q || out_ready_i;
  assign out_valid_o     = out_valid_q;
  assign angular_cmd_o   = out_ang_q;
  assign linear_cmd_o    = out_lin_q;
  assign heading_error_o = out_err_q;

  always_comb begin
    err_raw  = DW'(bearing) - DW'(hd_q);
    tol_ext  = DW'({1'b0, cfg.heading_tol});
    ptol_ext = DW'(cfg.position_tol);
    adx      = (dx_q < 0) ? DW'(-dx_q) : DW'(dx_q);
    ady      = (dy_q < 0) ? DW'(-dy_q) : DW'(dy_q);

    err_d = err_q;
    if (bearing > 0) begin
      err_d = err_raw[ERR_W-1:0];
    end else if (bearing <= GAP_LOW) begin
      err_d = ERR_W'(err_raw + TWO_PI_A);
    end
    err_ext = DW'(err_d);

    lin_d = lin_q;
    if (err_ext > tol_ext) begin
      ang_d = ANG_W'({1'b0, cfg.turn_rate});
    end else if (err_ext < -tol_ext) begin
      ang_d = -ANG_W'({1'b0, cfg.turn_rate});
    end else begin
      ang_d = '0;
      lin_d = (adx > ptol_ext || ady > ptol_ext) ? cfg.forward_speed : '0;
    end
  end

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q && !out_ready_i;
    case (state_q)
      S_IDLE:  if (in_acc) state_d = S_START;
      S_START: state_d = S_WAIT;
      S_WAIT:  if (cordic_done) state_d = S_PUSH;
      S_PUSH: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      err_q       <= '0;
      lin_q       <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (state_q == S_WAIT && cordic_done) begin
        err_q <= err_d;
        lin_q <= lin_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      dx_q <= DW'(cfg.goal_x) - DW'(pose_x_i);
      dy_q <= DW'(cfg.goal_y) - DW'(pose_y_i);
      hd_q <= pose_heading_i;
    end
    if (state_q == S_WAIT && cordic_done) begin
      ang_q <= ang_d;
    end
    if (state_q == S_PUSH && out_free) begin
      out_ang_q <= ang_q;
      out_lin_q <= lin_q;
      out_err_q <= err_q;
    end
  end

endmodule

`default_nettype wire

/* design/ggbb_cfg_regs.sv */
`timescale 1ns / 1ps
`default_nettype none

module ggbb_cfg_regs (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [ggbb_pkg::CIDX_W-1:0]    cfg_index_i,
  input  logic [ggbb_pkg::CDATA_W-1:0]   cfg_data_i,
  output ggbb_pkg::cfg_t                 cfg_o
);
  import ggbb_pkg::*;

  cfg_t cfg_q, cfg_d;

  assign cfg_ready_o = 1'b1;
  assign cfg_o       = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_reg_e'(cfg_index_i))
        REG_GOAL_X:    cfg_d.goal_x        = cfg_data_i;
        REG_GOAL_Y:    cfg_d.goal_y        = cfg_data_i;
        REG_TURN_RATE: cfg_d.turn_rate     = cfg_data_i[SPD_W-1:0];
        REG_FWD_SPEED: cfg_d.forward_speed = cfg_data_i[SPD_W-1:0];
        REG_HEAD_TOL:  cfg_d.heading_tol   = cfg_data_i[HTOL_W-1:0];
        REG_POS_TOL:   cfg_d.position_tol  = cfg_data_i[PTOL_W-1:0];
        default:       cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.goal_x        <= '0;
      cfg_q.goal_y        <= '0;
      cfg_q.turn_rate     <= SPD_W'(307);
      cfg_q.forward_speed <= SPD_W'(205);
      cfg_q.heading_tol   <= HTOL_W'(102);
      cfg_q.position_tol  <= PTOL_W'(51);
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

`default_nettype wire

/* design/ggbb_cordic.sv */
`timescale 1ns / 1ps
`default_nettype none

module ggbb_cordic (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start_i,
  input  logic signed [ggbb_pkg::DW-1:0]       dx_i,
  input  logic signed [ggbb_pkg::DW-1:0]       dy_i,
  output logic                                 done_o,
  output logic signed [ggbb_pkg::HEAD_W-1:0]   bearing_o
);
  import ggbb_pkg::*;

  typedef enum logic [2:0] {
    C_IDLE = 3'b001,
    C_RUN  = 3'b010,
    C_FIN  = 3'b100
  } cordic_state_e;

  cordic_state_e state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic signed [XW-1:0] x_q, x_d, y_q, y_d;
  logic signed [ZW-1:0] z_q, z_d;
  logic signed [HEAD_W-1:0] bearing_q, bearing_d;
  logic done_q, done_d;

  logic signed [XW-1:0] x_ld, y_ld, x_sh, y_sh;
  logic signed [ZW-1:0] z_rnd;
  logic signed [15:0]   r_full;

  assign done_o    = done_q;
  assign bearing_o = bearing_q;

  always_comb begin
    x_ld   = XW'(dx_i) <<< 24;
    y_ld   = XW'(dy_i) <<< 24;
    x_sh   = x_q >>> cnt_q;
    y_sh   = y_q >>> cnt_q;
    z_rnd  = z_q + ZW'(8);
    r_full = z_rnd[ZW-1:4];

    state_d   = state_q;
    cnt_d     = cnt_q;
    x_d       = x_q;
    y_d       = y_q;
    z_d       = z_q;
    bearing_d = bearing_q;
    done_d    = 1'b0;

    case (state_q)
      C_IDLE: begin
        if (start_i) begin
          if (dy_i == '0) begin
            bearing_d = (dx_i < 0) ? PI_A[HEAD_W-1:0] : '0;
            done_d    = 1'b1;
          end else if (dx_i == '0) begin
            bearing_d = (dy_i > 0) ? HALF_PI_A : -HALF_PI_A;
            done_d    = 1'b1;
          end else begin
            cnt_d = '0;
            if (dx_i < 0) begin
              x_d = -x_ld;
              y_d = -y_ld;
              z_d = (dy_i >= 0) ? PI_Q15 : -PI_Q15;
            end else begin
              x_d = x_ld;
              y_d = y_ld;
              z_d = '0;
            end
            state_d = C_RUN;
          end
        end
      end
      C_RUN: begin
        if (y_q >= 0) begin
          x_d = x_q + y_sh;
          y_d = y_q - x_sh;
          z_d = z_q + atan_q15(cnt_q);
        end else begin
          x_d = x_q - y_sh;
          y_d = y_q + x_sh;
          z_d = z_q - atan_q15(cnt_q);
        end
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CNT_W'(CORDIC_ITERS - 1)) begin
          state_d = C_FIN;
        end
      end
      C_FIN: begin
        if (r_full > PI_A) begin
          bearing_d = PI_A[HEAD_W-1:0];
        end else if (r_full < -PI_A) begin
          bearing_d = -PI_A[HEAD_W-1:0];
        end else begin
          bearing_d = r_full[HEAD_W-1:0];
        end
        done_d  = 1'b1;
        state_d = C_IDLE;
      end
      default: state_d = C_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= C_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cnt_q     <= cnt_d;
    x_q       <= x_d;
    y_q       <= y_d;
    z_q       <= z_d;
    bearing_q <= bearing_d;
  end

endmodule

`default_nettype wire

/* design/ggbb_checker.sv */
`timescale 1ns / 1ps
`default_nettype none

module ggbb_checker (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_valid_i,
  input  logic                                  cfg_ready_o,
  input  logic [ggbb_pkg::CIDX_W-1:0]           cfg_index_i,
  input  logic [ggbb_pkg::CDATA_W-1:0]          cfg_data_i,
  input  logic                                  in_valid_i,
  input  logic                                  in_ready_o,
  input  logic signed [ggbb_pkg::POS_W-1:0]     pose_x_i,
  input  logic signed [ggbb_pkg::POS_W-1:0]     pose_y_i,
  input  logic signed [ggbb_pkg::HEAD_W-1:0]    pose_heading_i,
  input  logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  input  logic signed [ggbb_pkg::ANG_W-1:0]     angular_cmd_o,
  input  logic [ggbb_pkg::SPD_W-1:0]            linear_cmd_o,
  input  logic signed [ggbb_pkg::ERR_W-1:0]     heading_error_o
);

  // result held while stalled
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(angular_cmd_o)
      && $stable(linear_cmd_o) && $stable(heading_error_o))
    else $error("result changed while stalled");

  // busy after taking an item
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("ready right after accept");

  // new result only comes out of a busy period
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> !$past(in_ready_o))
    else $error("result without work");

  // no result rises too early after an item is taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> ##1 !$rose(out_valid_o))
    else $error("result too early");

endmodule

bind go_to_goal_bang_bang_steering ggbb_checker u_ggbb_checker (.*);

`default_nettype wire

/* tb/steer_tb_pkg.sv */
`timescale 1ns / 1ps

package steer_tb_pkg;
  import ggbb_pkg::*;

  localparam int     ANGLE_PI      = 6434;
  localparam int     ANGLE_HALF_PI = 3217;
  localparam int     ANGLE_TWO_PI  = 12868;
  localparam int     GAP_EDGE      = -410;
  localparam longint Q15_PI        = 102944;
  localparam longint ATAN_STEP_Q15 [ATAN_LEN] = '{
    25736, 15193, 8027, 4075, 2045, 1024, 512, 256,
    128, 64, 32, 16, 8, 4, 2, 1,
    0, 0, 0, 0, 0, 0, 0, 0
  };

  // indexes past the register map, the block must ignore them
  localparam logic [CIDX_W-1:0] CFG_IDX_SPARE0 = 3'd6;
  localparam logic [CIDX_W-1:0] CFG_IDX_SPARE1 = 3'd7;

  typedef struct packed {
    logic signed [ANG_W-1:0] angular;
    logic [SPD_W-1:0]        linear;
    logic signed [ERR_W-1:0] head_err;
  } steer_cmd_t;

  class steer_cmd_board;
    int goal_x, goal_y;
    int turn_rate, fwd_speed, head_tol, pos_tol;
    int held_err, held_fwd;
    steer_cmd_t due_cmds[$];
    int errors;

    function new();
      goal_x    = 0;
      goal_y    = 0;
      turn_rate = 307;
      fwd_speed = 205;
      head_tol  = 102;
      pos_tol   = 51;
      held_err  = 0;
      held_fwd  = 0;
      errors    = 0;
    endfunction

    function void load_reg(logic [CIDX_W-1:0] idx, logic [CDATA_W-1:0] data);
      case (idx)
        REG_GOAL_X:    goal_x    = int'($signed(data));
        REG_GOAL_Y:    goal_y    = int'($signed(data));
        REG_TURN_RATE: turn_rate = int'(data[SPD_W-1:0]);
        REG_FWD_SPEED: fwd_speed = int'(data[SPD_W-1:0]);
        REG_HEAD_TOL:  head_tol  = int'(data[HTOL_W-1:0]);
        REG_POS_TOL:   pos_tol   = int'(data[PTOL_W-1:0]);
        default: ;
      endcase
    endfunction

    // atan2(dy, dx) in 1/2048 rad, vectoring CORDIC in Q15
    function int bearing_of(int dx, int dy);
      longint x, y, z, nx, ny, r;
      if (dy == 0) return (dx < 0) ? ANGLE_PI : 0;
      if (dx == 0) return (dy > 0) ? ANGLE_HALF_PI : -ANGLE_HALF_PI;
      x = longint'(dx) <<< 24;
      y = longint'(dy) <<< 24;
      z = 0;
      if (x < 0) begin
        z = (y >= 0) ? Q15_PI : -Q15_PI;
        x = -x;
        y = -y;
      end
      for (int i = 0; i < CORDIC_ITERS; i++) begin
        if (y >= 0) begin
          nx = x + (y >>> i);
          ny = y - (x >>> i);
          z  = z + ATAN_STEP_Q15[i];
        end else begin
          nx = x - (y >>> i);
          ny = y + (x >>> i);
          z  = z - ATAN_STEP_Q15[i];
        end
        x = nx;
        y = ny;
      end
      r = (z + 8) >>> 4;
      if (r > ANGLE_PI) r = ANGLE_PI;
      if (r < -ANGLE_PI) r = -ANGLE_PI;
      return int'(r);
    endfunction

    function void take_pose(int px, int py, int hd);
      int dx, dy, b, ang, adx, ady;
      steer_cmd_t cmd;
      dx = goal_x - px;
      dy = goal_y - py;
      b  = bearing_of(dx, dy);
      if (b > 0) held_err = b - hd;
      else if (b <= GAP_EDGE) held_err = b - hd + ANGLE_TWO_PI;
      if (held_err > head_tol) begin
        ang = turn_rate;
      end else if (held_err < -head_tol) begin
        ang = -turn_rate;
      end else begin
        ang = 0;
        adx = (dx < 0) ? -dx : dx;
        ady = (dy < 0) ? -dy : dy;
        held_fwd = (adx > pos_tol || ady > pos_tol) ? fwd_speed : 0;
      end
      cmd.angular  = ANG_W'(ang);
      cmd.linear   = SPD_W'(held_fwd);
      cmd.head_err = ERR_W'(held_err);
      due_cmds.push_back(cmd);
    endfunction

    function void match_cmd(logic signed [ANG_W-1:0] ang, logic [SPD_W-1:0] lin,
                            logic signed [ERR_W-1:0] err);
      steer_cmd_t want;
      if (due_cmds.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("%0t: unexpected item: angular %0d linear %0d heading error %0d",
                   $realtime, ang, lin, err);
        return;
      end
      want = due_cmds.pop_front();
      if (want.angular !== ang || want.linear !== lin || want.head_err !== err) begin
        errors++;
        if (errors <= 10)
          $display("%0t: mismatch: angular %0d/%0d linear %0d/%0d heading error %0d/%0d",
                   $realtime, want.angular, ang, want.linear, lin, want.head_err, err);
      end
    endfunction
  endclass

endpackage

/* tb/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
  import ggbb_pkg::*;
  import steer_tb_pkg::*;

  localparam int IDLE_LIMIT    = 4000;
  localparam int SETTLE_CYCLES = 30;
  localparam int RAND_PHASES   = 8;
  localparam int PHASE_ITEMS   = 180;

  logic                     clk_i;
  logic                     rst_ni         = 1'b0;
  logic                     cfg_valid_i    = 1'b0;
  logic                     cfg_ready_o;
  logic [CIDX_W-1:0]        cfg_index_i    = '0;
  logic [CDATA_W-1:0]       cfg_data_i     = '0;
  logic                     in_valid_i     = 1'b0;
  logic                     in_ready_o;
  logic signed [POS_W-1:0]  pose_x_i       = '0;
  logic signed [POS_W-1:0]  pose_y_i       = '0;
  logic signed [HEAD_W-1:0] pose_heading_i = '0;
  logic                     out_valid_o;
  logic                     out_ready_i    = 1'b0;
  logic signed [ANG_W-1:0]  angular_cmd_o;
  logic [SPD_W-1:0]         linear_cmd_o;
  logic signed [ERR_W-1:0]  heading_error_o;

  steer_cmd_board board;
  int burst_left  = 0;
  int rdy_left    = 0;
  int rdy_mode    = 0;
  int idle_cycles = 0;

  go_to_goal_bang_bang_steering dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .pose_x_i       (pose_x_i),
    .pose_y_i       (pose_y_i),
    .pose_heading_i (pose_heading_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .angular_cmd_o  (angular_cmd_o),
    .linear_cmd_o   (linear_cmd_o),
    .heading_error_o(heading_error_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  function automatic int clamp_pos(int v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  function automatic int clamp_head(int v);
    if (v > ANGLE_PI) return ANGLE_PI;
    if (v < -ANGLE_PI) return -ANGLE_PI;
    return v;
  endfunction

  // heading near a positive bearing so the dead band gets hit, random otherwise
  function automatic int aim_heading(int px, int py);
    int b, w;
    b = board.bearing_of(board.goal_x - px, board.goal_y - py);
    w = board.head_tol + 64;
    if (b > 0) return clamp_head(b + int'($urandom_range(0, 2 * w)) - w);
    return int'($urandom_range(0, 2 * ANGLE_PI)) - ANGLE_PI;
  endfunction

  function automatic logic [CDATA_W-1:0] pick_reg(int lo, int hi);
    case ($urandom_range(0, 5))
      0:       return CDATA_W'(lo);
      1:       return CDATA_W'(hi);
      2:       return CDATA_W'($urandom_range(0, 65535));
      default: return CDATA_W'(lo + int'($urandom_range(0, hi - lo)));
    endcase
  endfunction

  task automatic write_reg(input logic [CIDX_W-1:0] idx, input logic [CDATA_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    board.load_reg(idx, data);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (board.due_cmds.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic configure(input logic [CDATA_W-1:0] gx, gy, tr, fs, ht, pt);
    drain();
    write_reg(REG_GOAL_X, gx);
    write_reg(REG_GOAL_Y, gy);
    write_reg(REG_TURN_RATE, tr);
    write_reg(REG_FWD_SPEED, fs);
    write_reg(REG_HEAD_TOL, ht);
    write_reg(REG_POS_TOL, pt);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic push_pose(input int px, py, hd);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 48);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
      if (gap != 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    in_valid_i     <= 1'b1;
    pose_x_i       <= POS_W'(px);
    pose_y_i       <= POS_W'(py);
    pose_heading_i <= HEAD_W'(hd);
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    board.take_pose(px, py, hd);
  endtask

  task automatic random_pose();
    int px, py, hd, dx, dy, span, kind;
    kind = $urandom_range(0, 9);
    px = int'($urandom_range(0, 65535)) - 32768;
    py = int'($urandom_range(0, 65535)) - 32768;
    case (kind)
      4, 5, 6: begin
        span = (board.pos_tol < 4000) ? 2 * board.pos_tol + 8 : 8000;
        px = clamp_pos(board.goal_x + int'($urandom_range(0, 2 * span)) - span);
        py = clamp_pos(board.goal_y + int'($urandom_range(0, 2 * span)) - span);
      end
      7: begin
        if ($urandom_range(0, 1)) px = board.goal_x;
        else py = board.goal_y;
      end
      8: begin
        // small negative bearing, around the gap band
        dx = $urandom_range(512, 40000);
        dy = -int'($urandom_range(0, dx / 4));
        px = clamp_pos(board.goal_x - dx);
        py = clamp_pos(board.goal_y - dy);
      end
      default: ;
    endcase
    if (kind >= 4 || $urandom_range(0, 2) == 0) hd = aim_heading(px, py);
    else hd = int'($urandom_range(0, 2 * ANGLE_PI)) - ANGLE_PI;
    push_pose(px, py, hd);
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i)
      board.match_cmd(angular_cmd_o, linear_cmd_o, heading_error_o);
    if (rdy_left == 0) begin
      rdy_mode <= $urandom_range(0, 2);
      rdy_left <= $urandom_range(20, 200);
    end else begin
      rdy_left <= rdy_left - 1;
    end
    case (rdy_mode)
      0:       out_ready_i <= 1'b1;
      1:       out_ready_i <= 1'($urandom_range(0, 1));
      default: out_ready_i <= ($urandom_range(0, 15) == 0);
    endcase
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == IDLE_LIMIT) begin
      $display("go_to_goal_bang_bang_steering test failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int hold_at;
    board = new();
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings: goal at origin
    push_pose(0, 0, 0);
    push_pose(-100, 0, 0);
    push_pose(100, 0, ANGLE_PI);
    push_pose(0, -100, ANGLE_HALF_PI);
    push_pose(0, 100, -ANGLE_HALF_PI);
    push_pose(-20000, 1000, 0);
    push_pose(-10000, 2100, -ANGLE_PI);
    push_pose(32767, -32768, -ANGLE_PI);
    push_pose(-32768, 32767, ANGLE_PI);
    push_pose(30, -40, board.bearing_of(-30, 40));
    push_pose(0, -100, 3115);
    push_pose(0, -100, 3114);
    push_pose(0, -100, 3319);
    push_pose(0, -100, 3320);
    push_pose(100, 1, ANGLE_PI);

    configure(16'h8000, 16'h7FFF, 16'd1023, 16'd1023, 16'd0, 16'd0);
    push_pose(32767, -32768, board.bearing_of(-65535, 65535));
    push_pose(-32768, 32767, 0);
    push_pose(-32767, 32767, 0);

    configure(16'h7FFF, 16'h8000, 16'hFFFF, 16'hFC00, 16'hFFFF, 16'hFFFF);
    @(posedge clk_i);
    write_reg(CFG_IDX_SPARE0, 16'hFFFF);
    write_reg(CFG_IDX_SPARE1, 16'h0000);
    cfg_valid_i <= 1'b0;
    push_pose(-32768, 32767, -ANGLE_PI);
    push_pose(32767, -32768, ANGLE_PI);
    push_pose(0, 0, 0);
    push_pose(32767, -32767, ANGLE_PI);

    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      configure(pick_reg(-32768, 32767), pick_reg(-32768, 32767),
                pick_reg(0, 1023), pick_reg(0, 1023),
                (ph % 2) ? pick_reg(0, 300) : pick_reg(0, 6434),
                (ph % 3 == 0) ? pick_reg(0, 32767) : pick_reg(0, 2000));
      hold_at = $urandom_range(20, PHASE_ITEMS - 20);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (n == hold_at) drain();
        random_pose();
      end
    end

    drain();
    if (board.errors == 0 && board.due_cmds.size() == 0) begin
      $display("go_to_goal_bang_bang_steering test passed");
    end else begin
      $display("go_to_goal_bang_bang_steering test failed");
    end
    $finish;
  end

endmodule

/* filelist.f */
design/ggbb_pkg.sv
design/ggbb_cfg_regs.sv
design/ggbb_cordic.sv
design/go_to_goal_bang_bang_steering.sv
design/ggbb_checker.sv
tb/steer_tb_pkg.sv
tb/tb_top.sv
